/* hw/rtl/qbs_pkg.sv */
`timescale 1ns / 1ps
// qbs_pkg: shared widths, constants and types for the quadratic bezier sampler
// no dependencies; imported by qbs_seq, qbs_lane and quadratic_bezier_sampler
package qbs_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_SAMPLES  = 64;

    // t runs 0 .. 1.0 inclusive, so one integer bit above the fraction
    localparam int T_WIDTH      = FRAC_BITS + 1;
    localparam int IDX_WIDTH    = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_WIDTH    = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = T_WIDTH;
    localparam int NUM_LANES    = 3;
    localparam int LANE_DEPTH   = 6;

    localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_T_STEP       = 2'd1
    } t_cfg_idx;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // control points of one axis
    typedef struct packed {
        t_coord c0;
        t_coord c1;
        t_coord c2;
    } t_axis_pts;

    typedef t_axis_pts [NUM_LANES-1:0] t_curve;

    // sideband that travels beside the lane datapath
    typedef struct packed {
        logic                 valid;
        logic [IDX_WIDTH-1:0] index;
        logic                 last;
    } t_tag;

endpackage

/* hw/rtl/qbs_seq.sv */
`timescale 1ns / 1ps
// qbs_seq: input word buffer and per-sample sequencer (index, t, last flag)
// depends on qbs_pkg
module qbs_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  qbs_pkg::t_curve               i_curve,
    input  logic [qbs_pkg::CNT_WIDTH-1:0] i_sample_count,
    input  logic [qbs_pkg::T_WIDTH-1:0]   i_t_step,
    input  logic                          i_adv,
    output qbs_pkg::t_tag                 o_tag,
    output logic [qbs_pkg::T_WIDTH-1:0]   o_t,
    output qbs_pkg::t_curve               o_curve
);
    import qbs_pkg::*;

    logic                  r_pend_valid;
    t_curve                r_pend_curve;
    logic                  r_busy;
    logic [IDX_WIDTH-1:0]  r_k;
    logic [IDX_WIDTH-1:0]  r_n_last;
    logic [T_WIDTH-1:0]    r_step;
    logic [T_WIDTH-1:0]    r_acc;
    t_curve                r_curve;

    logic                  w_last;
    logic                  w_load;
    logic                  w_accept;
    logic [IDX_WIDTH-1:0]  w_n_last;
    logic [T_WIDTH:0]      w_sum;
    logic [T_WIDTH-1:0]    n_acc;

    assign w_last   = (r_k == r_n_last);
    assign w_load   = r_pend_valid && (!r_busy || (i_adv && w_last));
    assign w_accept = i_in_valid && !r_pend_valid;

    // clamp sample count into 2 .. MAX_SAMPLES, keep count minus one
    always_comb begin
        if (i_sample_count < CNT_WIDTH'(2)) begin
            w_n_last = IDX_WIDTH'(1);
        end else if (i_sample_count > CNT_WIDTH'(MAX_SAMPLES)) begin
            w_n_last = IDX_WIDTH'(MAX_SAMPLES - 1);
        end else begin
            w_n_last = IDX_WIDTH'(i_sample_count - CNT_WIDTH'(1));
        end
    end

    // t accumulates and saturates at 1.0
    assign w_sum = {1'b0, r_acc} + {1'b0, r_step};
    assign n_acc = (w_sum > {1'b0, T_ONE}) ? T_ONE : w_sum[T_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_k          <= '0;
            r_acc        <= '0;
        end else begin
            if (w_accept) begin
                r_pend_valid <= 1'b1;
            end else if (w_load) begin
                r_pend_valid <= 1'b0;
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_acc  <= '0;
            end else if (i_adv && r_busy) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_k   <= r_k + IDX_WIDTH'(1);
                    r_acc <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_curve <= i_curve;
        end
        if (w_load) begin
            r_curve  <= r_pend_curve;
            r_n_last <= w_n_last;
            r_step   <= i_t_step;
        end
    end

    assign o_in_stall  = r_pend_valid;
    assign o_tag.valid = r_busy;
    assign o_tag.index = r_k;
    assign o_tag.last  = w_last;
    assign o_t         = w_last ? T_ONE : r_acc;
    assign o_curve     = r_curve;

endmodule

/* hw/rtl/qbs_lane.sv */
`timescale 1ns / 1ps
// qbs_lane: one axis of de casteljau evaluation, six register stages
// depends on qbs_pkg
module qbs_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  qbs_pkg::t_axis_pts          i_pts,
    input  logic [qbs_pkg::T_WIDTH-1:0] i_t,
    output qbs_pkg::t_coord             o_coord
);
    import qbs_pkg::*;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SUM_W  = COORD_WIDTH + 2;
    localparam int PROD_W = DIFF_W + T_WIDTH + 1;

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;

    function automatic t_diff f_diff(input t_coord a, input t_coord b);
        f_diff = t_diff'(b) - t_diff'(a);
    endfunction

    function automatic t_prod f_mul(input t_diff d, input logic [T_WIDTH-1:0] t);
        f_mul = t_prod'(d) * t_prod'($signed({1'b0, t}));
    endfunction

    // a + floor(t * (b - a) / 2^frac), equal to floor(((1-t)a + tb) / 2^frac)
    function automatic t_coord f_fin(input t_coord a, input t_prod m);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + $signed(m[FRAC_BITS +: SUM_W]);
        f_fin = s[COORD_WIDTH-1:0];
    endfunction

    logic [T_WIDTH-1:0] r_t1, r_t2, r_t3, r_t4;
    t_coord             r_a1, r_b1, r_a2, r_b2;
    t_diff              r_d01, r_d12;
    t_prod              r_m01, r_m12;
    t_coord             r_ab3, r_bc3;
    t_coord             r_ab4, r_ab5;
    t_diff              r_d4;
    t_prod              r_m5;
    t_coord             r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // first level: differences
            r_a1  <= i_pts.c0;
            r_b1  <= i_pts.c1;
            r_d01 <= f_diff(i_pts.c0, i_pts.c1);
            r_d12 <= f_diff(i_pts.c1, i_pts.c2);
            r_t1  <= i_t;
            // first level: products
            r_a2  <= r_a1;
            r_b2  <= r_b1;
            r_m01 <= f_mul(r_d01, r_t1);
            r_m12 <= f_mul(r_d12, r_t1);
            r_t2  <= r_t1;
            // first level: sums
            r_ab3 <= f_fin(r_a2, r_m01);
            r_bc3 <= f_fin(r_b2, r_m12);
            r_t3  <= r_t2;
            // second level
            r_ab4 <= r_ab3;
            r_d4  <= f_diff(r_ab3, r_bc3);
            r_t4  <= r_t3;
            r_ab5 <= r_ab4;
            r_m5  <= f_mul(r_d4, r_t4);
            r_out <= f_fin(r_ab5, r_m5);
        end
    end

    assign o_coord = r_out;

endmodule

/* hw/rtl/quadratic_bezier_sampler.sv */
`timescale 1ns / 1ps
// quadratic_bezier_sampler: top level, config registers, three axis lanes, merge stage
// depends on qbs_pkg, qbs_seq, qbs_lane
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------
//   in      | i_in_valid / o_in_stall | i_p0_* i_p1_* i_p2_* (x, y, z)
//   out     | o_out_valid / i_out_stall | o_out_x/y/z, o_sample_index, o_last
//   cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one sample leaves per cycle while the output is not stalled, and a curve gives
// sample_count samples (2 .. 64); the sample sequencer is the pacing unit and
// reloads from a one-word buffer with no gap between curves.
// reset clears the buffer, sequencer and all valid bits; config returns to 5 / 16384.
// a stalled output word freezes the whole sample pipeline; the input buffer
// still takes one more word while the pipeline waits.
module quadratic_bezier_sampler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // curve input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  qbs_pkg::t_coord                i_p0_x,
    input  qbs_pkg::t_coord                i_p0_y,
    input  qbs_pkg::t_coord                i_p0_z,
    input  qbs_pkg::t_coord                i_p1_x,
    input  qbs_pkg::t_coord                i_p1_y,
    input  qbs_pkg::t_coord                i_p1_z,
    input  qbs_pkg::t_coord                i_p2_x,
    input  qbs_pkg::t_coord                i_p2_y,
    input  qbs_pkg::t_coord                i_p2_z,
    // sample output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output qbs_pkg::t_coord                o_out_x,
    output qbs_pkg::t_coord                o_out_y,
    output qbs_pkg::t_coord                o_out_z,
    output logic [qbs_pkg::IDX_WIDTH-1:0]  o_sample_index,
    output logic                           o_last,
    // config writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import qbs_pkg::*;

    // config registers
    logic [CNT_WIDTH-1:0] r_sample_count;
    logic [T_WIDTH-1:0]   r_t_step;

    // pipeline advance: everything moves unless the output word is held
    logic                 w_en;

    t_curve               w_in_curve;
    t_curve               w_seq_curve;
    t_tag                 w_seq_tag;
    logic [T_WIDTH-1:0]   w_seq_t;
    t_coord               w_lane_out [NUM_LANES];

    // sideband delay line matching the lane depth
    t_tag                 r_tag [LANE_DEPTH];

    // merged output word
    logic                 r_out_valid;
    t_coord               r_out_x;
    t_coord               r_out_y;
    t_coord               r_out_z;
    logic [IDX_WIDTH-1:0] r_out_index;
    logic                 r_out_last;

    assign w_en = !r_out_valid || !i_out_stall;

    // config port never holds off a write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= CNT_WIDTH'(5);
            r_t_step       <= T_WIDTH'(16384);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[CNT_WIDTH-1:0];
                CFG_T_STEP:       r_t_step       <= i_cfg_data[T_WIDTH-1:0];
                default:          ;  // unknown index, write dropped
            endcase
        end
    end

    // lane 0 is x, 1 is y, 2 is z
    assign w_in_curve[0] = '{c0: i_p0_x, c1: i_p1_x, c2: i_p2_x};
    assign w_in_curve[1] = '{c0: i_p0_y, c1: i_p1_y, c2: i_p2_y};
    assign w_in_curve[2] = '{c0: i_p0_z, c1: i_p1_z, c2: i_p2_z};

    qbs_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_curve        (w_in_curve),
        .i_sample_count (r_sample_count),
        .i_t_step       (r_t_step),
        .i_adv          (w_en),
        .o_tag          (w_seq_tag),
        .o_t            (w_seq_t),
        .o_curve        (w_seq_curve)
    );

    // one lane per axis, all fed the same t
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        qbs_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_pts   (w_seq_curve[g]),
            .i_t     (w_seq_t),
            .o_coord (w_lane_out[g])
        );
    end

    // index and last flag ride alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANE_DEPTH; i++) begin
                r_tag[i].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_tag[0] <= w_seq_tag;
            for (int i = 1; i < LANE_DEPTH; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    // merge stage: lane results plus sideband into one output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_tag[LANE_DEPTH-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x     <= w_lane_out[0];
            r_out_y     <= w_lane_out[1];
            r_out_z     <= w_lane_out[2];
            r_out_index <= r_tag[LANE_DEPTH-1].index;
            r_out_last  <= r_tag[LANE_DEPTH-1].last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_out_z        = r_out_z;
    assign o_sample_index = r_out_index;
    assign o_last         = r_out_last;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for quadratic_bezier_sampler, directed tests then random curves
// depends on qbs_pkg and the rtl of quadratic_bezier_sampler, qbs_seq and qbs_lane
module tb_top;

    import qbs_pkg::*;

    // bench timing
    localparam int  RESET_CYCLES   = 11;
    localparam int  SETTLE_CYCLES  = 24;      // drain time past the lane pipeline and merge stage, with margin
    localparam int  RANDOM_CURVES  = 355;
    localparam int  REPORT_LIMIT   = 10;
    localparam longint T_ONE_L     = longint'(1) << FRAC_BITS;

    // config indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // one input word: control point p[point][axis], axis 0..2 = x, y, z
    typedef struct {
        t_coord p [3][3];
    } t_tb_curve;

    // one output word as the bench expects it
    typedef struct {
        t_coord                x;
        t_coord                y;
        t_coord                z;
        logic [IDX_WIDTH-1:0]  index;
        logic                  last;
    } t_tb_sample;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // curve input channel
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_coord i_p0_x = '0, i_p0_y = '0, i_p0_z = '0;
    t_coord i_p1_x = '0, i_p1_y = '0, i_p1_z = '0;
    t_coord i_p2_x = '0, i_p2_y = '0, i_p2_z = '0;

    // sample output channel
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_coord                o_out_x, o_out_y, o_out_z;
    logic [IDX_WIDTH-1:0]  o_sample_index;
    logic                  o_last;

    // config write channel
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // bench copy of the config registers, reset values of the block
    logic [CNT_WIDTH-1:0]  cfg_count = 7'd5;
    logic [T_WIDTH-1:0]    cfg_step  = 17'd16384;

    // samples still owed by the block, oldest first
    t_tb_sample expected_samples [$];

    int n_errors     = 0;
    int curves_sent  = 0;
    int in_gap_max   = 0;     // per-word idle draw on the curve side
    int out_gap_max  = 0;     // per-word stall draw on the sample side

    always #1 i_clk = ~i_clk;

    quadratic_bezier_sampler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_p0_x         (i_p0_x),
        .i_p0_y         (i_p0_y),
        .i_p0_z         (i_p0_z),
        .i_p1_x         (i_p1_x),
        .i_p1_y         (i_p1_y),
        .i_p1_z         (i_p1_z),
        .i_p2_x         (i_p2_x),
        .i_p2_y         (i_p2_y),
        .i_p2_z         (i_p2_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_sample_index (o_sample_index),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // one de casteljau step: ((1 - t) * a + t * b) floored back to Q7.16
    function automatic longint blend(longint a, longint b, longint t);
        return ((T_ONE_L - t) * a + t * b) >>> FRAC_BITS;
    endfunction

    // expand one accepted curve into the samples it must produce
    function automatic void sample_curve(t_tb_curve c);
        int            n;
        longint        t;
        longint        ab;
        longint        bc;
        t_coord        res [3];
        t_tb_sample    s;
        n = int'(cfg_count);
        // out-of-range counts are clamped to the legal span
        if (n < 2)
            n = 2;
        if (n > MAX_SAMPLES)
            n = MAX_SAMPLES;
        for (int k = 0; k < n; k++) begin
            t = longint'(k) * longint'(cfg_step);
            // t saturates at one, and the final sample always sits at one
            if (t > T_ONE_L || k == n - 1)
                t = T_ONE_L;
            for (int a = 0; a < 3; a++) begin
                ab     = blend(c.p[0][a], c.p[1][a], t);
                bc     = blend(c.p[1][a], c.p[2][a], t);
                res[a] = t_coord'(blend(ab, bc, t));
            end
            s.x     = res[0];
            s.y     = res[1];
            s.z     = res[2];
            s.index = IDX_WIDTH'(k);
            s.last  = (k == n - 1);
            expected_samples = {expected_samples, s};
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_coord random_coord();
        int v;
        v = $urandom_range(0, 511);
        case ($urandom_range(0, 7))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return t_coord'(v - 256);
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_tb_curve random_curve();
        t_tb_curve c;
        for (int i = 0; i < 3; i++)
            for (int a = 0; a < 3; a++)
                c.p[i][a] = random_coord();
        return c;
    endfunction

    // same value on all three axes of each point
    function automatic t_tb_curve flat_curve(t_coord a, t_coord b, t_coord c);
        t_tb_curve r;
        for (int ax = 0; ax < 3; ax++) begin
            r.p[0][ax] = a;
            r.p[1][ax] = b;
            r.p[2][ax] = c;
        end
        return r;
    endfunction

    // either a quiet stretch or the full 0..6 idle range
    function automatic int pick_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : 6;
    endfunction

    // offer one curve word; valid stays high on return so back-to-back words
    // never see a low-high pair in one step
    task automatic send_curve(input t_tb_curve c);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_p0_x     <= c.p[0][0];
        i_p0_y     <= c.p[0][1];
        i_p0_z     <= c.p[0][2];
        i_p1_x     <= c.p[1][0];
        i_p1_y     <= c.p[1][1];
        i_p1_z     <= c.p[1][2];
        i_p2_x     <= c.p[2][0];
        i_p2_y     <= c.p[2][1];
        i_p2_z     <= c.p[2][2];
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sample_curve(c);
        curves_sent++;
    endtask

    // drop valid, let every owed sample drain, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; only called with the block idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        // unknown indexes leave both registers alone
        if (idx == CFG_SAMPLE_COUNT)
            cfg_count = data[CNT_WIDTH-1:0];
        else if (idx == CFG_T_STEP)
            cfg_step = data;
        @(posedge i_clk);
    endtask

    task automatic set_curve_shape(input int count, input int step);
        cfg_write(CFG_SAMPLE_COUNT, CFG_DATA_W'(count));
        cfg_write(CFG_T_STEP, CFG_DATA_W'(step));
    endtask

    // ------------------------------------------------------------------
    // sample side: stall driver and checker
    // ------------------------------------------------------------------

    // stall is drawn per sample word, from 0..out_gap_max, before taking it
    initial begin : stall_driver
        int w;
        forever begin
            w = $urandom_range(0, out_gap_max);
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // every taken sample word is matched against the oldest expectation
    always @(posedge i_clk) begin : sample_check
        t_tb_sample want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $display({"%0t: sample word with none pending: ",
                              "x=%0d y=%0d z=%0d k=%0d last=%0b"},
                             $realtime, o_out_x, o_out_y, o_out_z, o_sample_index, o_last);
            end else begin
                want = expected_samples.pop_front();
                if (o_out_x !== want.x || o_out_y !== want.y || o_out_z !== want.z ||
                    o_sample_index !== want.index || o_last !== want.last) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT)
                        $display({"%0t: sample mismatch: expected x=%0d y=%0d z=%0d k=%0d ",
                                  "last=%0b, got x=%0d y=%0d z=%0d k=%0d last=%0b"},
                                 $realtime, want.x, want.y, want.z, want.index, want.last,
                                 o_out_x, o_out_y, o_out_z, o_sample_index, o_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset config (5 samples, quarter steps), extreme flat curves
    task automatic test_reset_defaults();
        send_curve(flat_curve(COORD_MAX, COORD_MAX, COORD_MAX));
        send_curve(flat_curve(COORD_MIN, COORD_MIN, COORD_MIN));
        send_curve(flat_curve(COORD_MAX, COORD_MIN, COORD_MAX));
        wait_idle();
    endtask

    // sign and magnitude extremes spread across the control points
    task automatic test_coord_extremes();
        t_tb_curve c;
        set_curve_shape(3, 32768);
        send_curve(flat_curve(COORD_MIN, COORD_MAX, COORD_MIN));
        send_curve(flat_curve('0, COORD_MAX, COORD_MIN));
        c = flat_curve(COORD_MAX, COORD_MIN, COORD_MIN);
        c.p[1][1] = COORD_MAX;
        c.p[2][2] = t_coord'(-1);
        send_curve(c);
        wait_idle();
    endtask

    // counts below two and above the maximum are clamped
    task automatic test_count_clamp();
        in_gap_max  = 6;
        out_gap_max = 6;
        set_curve_shape(0, 65536);
        send_curve(random_curve());
        wait_idle();
        cfg_write(CFG_SAMPLE_COUNT, CFG_DATA_W'(1));
        send_curve(random_curve());
        wait_idle();
        set_curve_shape(64, 65536 / 63);
        send_curve(random_curve());
        wait_idle();
        cfg_write(CFG_SAMPLE_COUNT, CFG_DATA_W'(65));
        send_curve(random_curve());
        wait_idle();
        // all data bits high: count field reads 127
        cfg_write(CFG_SAMPLE_COUNT, '1);
        send_curve(random_curve());
        wait_idle();
    endtask

    // zero step, steps that run t past one, smallest and largest step
    task automatic test_step_edges();
        set_curve_shape(6, 0);
        send_curve(random_curve());
        wait_idle();
        set_curve_shape(5, 131071);
        send_curve(random_curve());
        wait_idle();
        set_curve_shape(4, 40000);
        send_curve(random_curve());
        wait_idle();
        set_curve_shape(3, 1);
        send_curve(random_curve());
        wait_idle();
        set_curve_shape(2, 65536);
        send_curve(random_curve());
        wait_idle();
    endtask

    // writes to undecoded indexes must not touch either register
    task automatic test_unused_index();
        set_curve_shape(4, 21845);
        cfg_write(CFG_IDX_SPARE2, '1);
        cfg_write(CFG_IDX_SPARE3, '0);
        send_curve(random_curve());
        wait_idle();
    endtask

    // random phases: new shape and idle pattern per phase, random curves inside
    task automatic test_random();
        int                    target;
        int                    r;
        int                    eff;
        logic [CFG_DATA_W-1:0] count_word;
        logic [CFG_DATA_W-1:0] step_word;
        target = curves_sent + RANDOM_CURVES;
        while (curves_sent < target) begin
            in_gap_max  = pick_gap();
            out_gap_max = pick_gap();
            r = $urandom_range(0, 9);
            // mostly short curves, now and then a medium one, the longest or a clamped count
            if (r < 6)
                count_word = CFG_DATA_W'($urandom_range(2, 8));
            else if (r == 6)
                count_word = CFG_DATA_W'(MAX_SAMPLES);
            else if (r == 7)
                count_word = CFG_DATA_W'($urandom_range(9, 40));
            else if (r == 8)
                count_word = CFG_DATA_W'($urandom_range(0, 1));
            else
                count_word = CFG_DATA_W'($urandom_range(65, 127));
            // junk above the count field is dropped by the register
            if ($urandom_range(0, 3) == 0)
                count_word[CFG_DATA_W-1:CNT_WIDTH] = (CFG_DATA_W-CNT_WIDTH)'($urandom);
            eff = int'(count_word[CNT_WIDTH-1:0]);
            if (eff < 2)
                eff = 2;
            if (eff > MAX_SAMPLES)
                eff = MAX_SAMPLES;
            case ($urandom_range(0, 7))
                4:       step_word = CFG_DATA_W'($urandom_range(0, 131071));
                5:       step_word = '0;
                6:       step_word = $urandom_range(0, 1) ? '1 : CFG_DATA_W'(T_ONE);
                7:       step_word = CFG_DATA_W'($urandom_range(1, 65536 / (eff - 1)));
                default: step_word = CFG_DATA_W'(65536 / (eff - 1));
            endcase
            if ($urandom_range(0, 7) == 0)
                cfg_write($urandom_range(0, 1) ? CFG_IDX_SPARE2 : CFG_IDX_SPARE3,
                          CFG_DATA_W'($urandom));
            cfg_write(CFG_SAMPLE_COUNT, count_word);
            if ($urandom_range(0, 4) != 0)
                cfg_write(CFG_T_STEP, step_word);
            repeat ($urandom_range(8, 32))
                send_curve(random_curve());
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_coord_extremes();
        test_count_clamp();
        test_step_edges();
        test_unused_index();
        test_random();

        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
